// ----- src/sqg_pkg.sv -----
// Shared types and constants for the shadow quad generator.
// No dependencies.
package sqg_pkg;

    // quad kind codes
    localparam logic [2:0] KIND_TOP    = 3'd0;
    localparam logic [2:0] KIND_RIGHT  = 3'd1;
    localparam logic [2:0] KIND_BOTTOM = 3'd2;
    localparam logic [2:0] KIND_LEFT   = 3'd3;
    localparam logic [2:0] KIND_BOX    = 3'd4;

    // config register indexes
    localparam logic [1:0] REG_LIGHT_X = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    // width of internal point math (coords plus carries)
    localparam int PW = 34;
    // magnitude width after normalization (below 2^23)
    localparam int MW = 23;
    // radicand width: s*2^14 < 2^61, padded to an even count for 2-bit root steps
    localparam int SW = 64;
    localparam int LW = 31;
    // dividend width: ax*2r*2^7 < 2^23*2^17*2^7
    localparam int NW = 47;

    // classified item passed from front to back
    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] x2;
        logic signed [PW-1:0] y2;
        logic [3:0]           face;   // top, right, bottom, left
    } item_t;

    // one point to push
    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
    } point_t;

endpackage

// ----- src/sqg_front.sv -----
// Front end: accepts rectangles, applies the light box test and facing tests.
// Depends on sqg_pkg.
module sqg_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] rect_x,
    input  logic signed [COORD_BITS-1:0] rect_y,
    input  logic [COORD_BITS-2:0]        rect_w,
    input  logic [COORD_BITS-2:0]        rect_h,
    input  logic signed [COORD_BITS-1:0] light_x,
    input  logic signed [COORD_BITS-1:0] light_y,
    input  logic [15:0]                  radius,
    output logic                         q_valid,
    input  logic                         q_ready,
    output sqg_pkg::item_t               q_item
);
    logic signed [sqg_pkg::PW-1:0] x, y, x2, y2, lx, ly, r;
    logic                          hit;
    logic                          q_valid_reg;
    sqg_pkg::item_t                q_item_reg, item_next;

    always_comb begin
        x  = sqg_pkg::PW'(rect_x);
        y  = sqg_pkg::PW'(rect_y);
        x2 = x + $signed({{(sqg_pkg::PW-COORD_BITS+1){1'b0}}, rect_w});
        y2 = y + $signed({{(sqg_pkg::PW-COORD_BITS+1){1'b0}}, rect_h});
        lx = sqg_pkg::PW'(light_x);
        ly = sqg_pkg::PW'(light_y);
        r  = $signed({{(sqg_pkg::PW-16){1'b0}}, radius});
        hit = (radius != 16'd0) && (lx - r < x2) && (lx + r > x)
              && (ly - r < y2) && (ly + r > y);
        item_next.x  = x;
        item_next.y  = y;
        item_next.x2 = x2;
        item_next.y2 = y2;
        item_next.face = {lx > x, ly < y2, lx < x2, ly > y};
    end

    assign in_ready = !q_valid_reg || q_ready;

    // one-entry output register; misses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (in_ready) begin
            q_valid_reg <= in_valid && hit;
        end
        if (in_ready && in_valid) begin
            q_item_reg <= item_next;
        end
    end

    assign q_valid = q_valid_reg;
    assign q_item  = q_item_reg;
endmodule

// ----- src/sqg_queue.sv -----
// Small FIFO between front end and back end.
// Depends on sqg_pkg.
module sqg_queue #(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  sqg_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output sqg_pkg::item_t rd_item
);
    localparam int DEPTH = 1 << DEPTH_LOG2;
    sqg_pkg::item_t         mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0]  wp_reg, rp_reg;
    logic [DEPTH_LOG2:0]    cnt_reg;
    logic                   wr, rd;

    assign wr_ready = cnt_reg != DEPTH[DEPTH_LOG2:0];
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            if (wr && !rd) cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr) cnt_reg <= cnt_reg - 1'b1;
        end
        if (wr) mem_reg[wp_reg] <= wr_item;
    end
endmodule

// ----- src/sqg_push.sv -----
// Pipelined point push: offset = |d| * 2r * 2^7 / isqrt(|d|^2 * 2^14), signed.
// Depends on sqg_pkg. One point enters per cycle.
module sqg_push (
    input  logic                          aclk,
    input  logic [15:0]                   radius,
    input  logic signed [sqg_pkg::PW-1:0] lx,
    input  logic signed [sqg_pkg::PW-1:0] ly,
    input  sqg_pkg::point_t               pt_in,
    output logic signed [sqg_pkg::PW-1:0] qx,
    output logic signed [sqg_pkg::PW-1:0] qy
);
    localparam int PW = sqg_pkg::PW;
    localparam int MW = sqg_pkg::MW;
    localparam int SW = sqg_pkg::SW;
    localparam int LW = sqg_pkg::LW;
    localparam int NW = sqg_pkg::NW;
    localparam int QS = 8;            // sqrt stages, 4 result bits each
    localparam int DS = 12;           // divide stages, 4 quotient bits each
    localparam int QW = 48;

    // stage 0: difference and magnitude
    logic signed [PW-1:0] s0_px, s0_py;
    logic [PW-1:0]        s0_ax, s0_ay;
    logic                 s0_nx, s0_ny;
    logic signed [PW-1:0] dx, dy;
    always_comb begin
        dx = pt_in.px - lx;
        dy = pt_in.py - ly;
    end
    always_ff @(posedge aclk) begin
        s0_px <= pt_in.px;
        s0_py <= pt_in.py;
        s0_nx <= dx[PW-1];
        s0_ny <= dy[PW-1];
        s0_ax <= dx[PW-1] ? PW'(-dx) : PW'(dx);
        s0_ay <= dy[PW-1] ? PW'(-dy) : PW'(dy);
    end

    // stage 1: normalize below 2^23 (priority shift, at most 11 places)
    logic [MW-1:0] s1_ax, s1_ay;
    logic signed [PW-1:0] s1_px, s1_py;
    logic          s1_nx, s1_ny;
    logic [PW-1:0] orv, tx, ty;
    always_comb begin
        orv = s0_ax | s0_ay;
        tx = s0_ax;
        ty = s0_ay;
        for (int k = PW - 1; k >= MW; k--) begin
            if (orv[k]) begin
                tx = s0_ax >> (k - MW + 1);
                ty = s0_ay >> (k - MW + 1);
                break;
            end
        end
    end
    always_ff @(posedge aclk) begin
        s1_ax <= tx[MW-1:0];
        s1_ay <= ty[MW-1:0];
        s1_px <= s0_px; s1_py <= s0_py;
        s1_nx <= s0_nx; s1_ny <= s0_ny;
    end

    // stage 2: squares and numerators
    logic [2*MW-1:0] s2_sx, s2_sy;
    logic [NW-1:0]   s2_nx_num, s2_ny_num;
    logic signed [PW-1:0] s2_px, s2_py;
    logic            s2_nx, s2_ny;
    always_ff @(posedge aclk) begin
        s2_sx <= s1_ax * s1_ax;
        s2_sy <= s1_ay * s1_ay;
        s2_nx_num <= {(NW-7)'(s1_ax) * (NW-7)'({radius, 1'b0}), 7'd0};
        s2_ny_num <= {(NW-7)'(s1_ay) * (NW-7)'({radius, 1'b0}), 7'd0};
        s2_px <= s1_px; s2_py <= s1_py;
        s2_nx <= s1_nx; s2_ny <= s1_ny;
    end

    // stage 3: radicand
    logic [SW-1:0] s3_s;
    logic [NW-1:0] s3_nxn, s3_nyn;
    logic signed [PW-1:0] s3_px, s3_py;
    logic s3_nx, s3_ny;
    always_ff @(posedge aclk) begin
        s3_s <= SW'({(SW-14)'(s2_sx) + (SW-14)'(s2_sy), 14'd0});
        s3_nxn <= s2_nx_num; s3_nyn <= s2_ny_num;
        s3_px <= s2_px; s3_py <= s2_py;
        s3_nx <= s2_nx; s3_ny <= s2_ny;
    end

    // sqrt pipeline, restoring, two bits of radicand per step, 4 steps/stage
    logic [SW-1:0] sq_rem  [QS+1];
    logic [LW:0]   sq_root [QS+1];
    logic [NW-1:0] sq_nxn [QS+1], sq_nyn [QS+1];
    logic signed [PW-1:0] sq_px [QS+1], sq_py [QS+1];
    logic sq_nx [QS+1], sq_ny [QS+1];
    logic [SW-1:0] sq_low [QS+1];
    assign sq_rem[0] = '0;
    assign sq_root[0] = '0;
    assign sq_low[0] = s3_s;
    assign sq_nxn[0] = s3_nxn; assign sq_nyn[0] = s3_nyn;
    assign sq_px[0] = s3_px; assign sq_py[0] = s3_py;
    assign sq_nx[0] = s3_nx; assign sq_ny[0] = s3_ny;
    for (genvar g = 0; g < QS; g++) begin : g_sq
        logic [SW-1:0] rem, low, trial;
        logic [LW:0]   root;
        always_comb begin
            rem = sq_rem[g];
            root = sq_root[g];
            low = sq_low[g];
            for (int j = 0; j < 4; j++) begin
                rem = {rem[SW-3:0], low[SW-1:SW-2]};
                low = {low[SW-3:0], 2'b00};
                trial = SW'({root, 2'b01});
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = {root[LW-1:0], 1'b1};
                end else begin
                    root = {root[LW-1:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            sq_rem[g+1] <= rem;
            sq_root[g+1] <= root;
            sq_low[g+1] <= low;
            sq_nxn[g+1] <= sq_nxn[g]; sq_nyn[g+1] <= sq_nyn[g];
            sq_px[g+1] <= sq_px[g]; sq_py[g+1] <= sq_py[g];
            sq_nx[g+1] <= sq_nx[g]; sq_ny[g+1] <= sq_ny[g];
        end
    end

    // two dividers in lockstep, restoring, 4 quotient bits per stage
    logic [LW:0]   dv_den [DS+1];
    logic [NW:0]   dv_rx [DS+1], dv_ry [DS+1];
    logic [QW-1:0] dv_qx [DS+1], dv_qy [DS+1];
    logic [QW-1:0] dv_lx [DS+1], dv_ly [DS+1];
    logic signed [PW-1:0] dv_px [DS+1], dv_py [DS+1];
    logic dv_nx [DS+1], dv_ny [DS+1];
    assign dv_den[0] = sq_root[QS];
    assign dv_rx[0] = '0; assign dv_ry[0] = '0;
    assign dv_qx[0] = '0; assign dv_qy[0] = '0;
    assign dv_lx[0] = QW'(sq_nxn[QS]); assign dv_ly[0] = QW'(sq_nyn[QS]);
    assign dv_px[0] = sq_px[QS]; assign dv_py[0] = sq_py[QS];
    assign dv_nx[0] = sq_nx[QS]; assign dv_ny[0] = sq_ny[QS];
    for (genvar g = 0; g < DS; g++) begin : g_dv
        logic [NW:0]   rx, ry;
        logic [QW-1:0] qxv, qyv, lxv, lyv;
        always_comb begin
            rx = dv_rx[g]; ry = dv_ry[g];
            qxv = dv_qx[g]; qyv = dv_qy[g];
            lxv = dv_lx[g]; lyv = dv_ly[g];
            for (int j = 0; j < 4; j++) begin
                rx = {rx[NW-1:0], lxv[QW-1]};
                ry = {ry[NW-1:0], lyv[QW-1]};
                lxv = {lxv[QW-2:0], 1'b0};
                lyv = {lyv[QW-2:0], 1'b0};
                if (rx >= (NW+1)'(dv_den[g])) begin
                    rx = rx - (NW+1)'(dv_den[g]);
                    qxv = {qxv[QW-2:0], 1'b1};
                end else begin
                    qxv = {qxv[QW-2:0], 1'b0};
                end
                if (ry >= (NW+1)'(dv_den[g])) begin
                    ry = ry - (NW+1)'(dv_den[g]);
                    qyv = {qyv[QW-2:0], 1'b1};
                end else begin
                    qyv = {qyv[QW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            dv_den[g+1] <= dv_den[g];
            dv_rx[g+1] <= rx; dv_ry[g+1] <= ry;
            dv_qx[g+1] <= qxv; dv_qy[g+1] <= qyv;
            dv_lx[g+1] <= lxv; dv_ly[g+1] <= lyv;
            dv_px[g+1] <= dv_px[g]; dv_py[g+1] <= dv_py[g];
            dv_nx[g+1] <= dv_nx[g]; dv_ny[g+1] <= dv_ny[g];
        end
    end

    // final: apply offset; zero length leaves point in place
    logic [PW-1:0] ox, oy;
    always_comb begin
        ox = (dv_den[DS] == '0) ? '0 : PW'(dv_qx[DS]);
        oy = (dv_den[DS] == '0) ? '0 : PW'(dv_qy[DS]);
    end
    always_ff @(posedge aclk) begin
        qx <= dv_nx[DS] ? dv_px[DS] - $signed(ox) : dv_px[DS] + $signed(ox);
        qy <= dv_ny[DS] ? dv_py[DS] - $signed(oy) : dv_py[DS] + $signed(oy);
    end
endmodule

// ----- src/sqg_back.sv -----
// Back end: sequences edge quads and the box quad, pushes far vertices through
// two push pipelines, and feeds an output FIFO. Depends on sqg_pkg, sqg_push.
module sqg_back #(
    parameter int COORD_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  sqg_pkg::item_t               q_item,
    input  logic signed [COORD_BITS-1:0] light_x,
    input  logic signed [COORD_BITS-1:0] light_y,
    input  logic [15:0]                  radius,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [8*COORD_BITS-1:0]      m_verts,
    output logic [2:0]                   m_kind,
    output logic                         m_last
);
    localparam int PW = sqg_pkg::PW;
    localparam int LAT = 1 + 1 + 1 + 1 + 8 + 12 + 1;
    localparam int FD_LOG2 = 5;
    localparam int FD = 1 << FD_LOG2;
    localparam int OW = 4 * PW + 3 + 1;

    // sequencer: walks face bits, then box
    logic [3:0]  done_reg;
    logic [3:0]  pend;
    logic [2:0]  kind;
    logic        issue;
    logic signed [PW-1:0] sx, sy, ex, ey;
    logic [FD_LOG2:0] credit_reg;
    logic        room;
    always_comb begin
        pend = q_item.face & ~done_reg;
        kind = sqg_pkg::KIND_BOX;
        if (pend[0]) kind = sqg_pkg::KIND_TOP;
        else if (pend[1]) kind = sqg_pkg::KIND_RIGHT;
        else if (pend[2]) kind = sqg_pkg::KIND_BOTTOM;
        else if (pend[3]) kind = sqg_pkg::KIND_LEFT;
        case (kind)
            sqg_pkg::KIND_TOP: begin
                sx = q_item.x; sy = q_item.y; ex = q_item.x2; ey = q_item.y;
            end
            sqg_pkg::KIND_RIGHT: begin
                sx = q_item.x2; sy = q_item.y; ex = q_item.x2; ey = q_item.y2;
            end
            sqg_pkg::KIND_BOTTOM: begin
                sx = q_item.x2; sy = q_item.y2; ex = q_item.x; ey = q_item.y2;
            end
            sqg_pkg::KIND_LEFT: begin
                sx = q_item.x; sy = q_item.y2; ex = q_item.x; ey = q_item.y;
            end
            default: begin
                sx = q_item.x; sy = q_item.y2; ex = q_item.x2; ey = q_item.y2;
            end
        endcase
        room = credit_reg != '0;
        issue = q_valid && room;
        q_ready = issue && (kind == sqg_pkg::KIND_BOX);
    end

    logic rd_fifo;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
            credit_reg <= FD[FD_LOG2:0];
        end else begin
            if (issue) begin
                if (kind == sqg_pkg::KIND_BOX) done_reg <= '0;
                else done_reg <= done_reg | (4'b0001 << kind[1:0]);
            end
            credit_reg <= credit_reg - (FD_LOG2+1)'(issue) + (FD_LOG2+1)'(rd_fifo);
        end
    end

    // push pipelines for end point and start point
    sqg_pkg::point_t pe, ps;
    logic signed [PW-1:0] pex, pey, psx, psy, lxw, lyw;
    assign lxw = PW'(light_x);
    assign lyw = PW'(light_y);
    assign pe = '{px: ex, py: ey};
    assign ps = '{px: sx, py: sy};
    sqg_push u_push_e (.aclk, .radius, .lx(lxw), .ly(lyw), .pt_in(pe), .qx(pex), .qy(pey));
    sqg_push u_push_s (.aclk, .radius, .lx(lxw), .ly(lyw), .pt_in(ps), .qx(psx), .qy(psy));

    // side delay line carrying the unpushed vertices and tags
    logic [LAT-1:0] dl_v_reg;
    logic [OW-1:0]  dl_d_reg [LAT];
    logic [OW-1:0]  dl_in;
    always_comb begin
        if (kind == sqg_pkg::KIND_BOX)
            dl_in = {q_item.x, q_item.y, q_item.x2, q_item.y2, kind, 1'b1};
        else
            dl_in = {sx, sy, ex, ey, kind, 1'b0};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) dl_v_reg <= '0;
        else dl_v_reg <= {dl_v_reg[LAT-2:0], issue};
        dl_d_reg[0] <= dl_in;
        for (int k = 1; k < LAT; k++) dl_d_reg[k] <= dl_d_reg[k-1];
    end

    // combine and saturate
    function automatic logic [COORD_BITS-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi, lo;
        hi = PW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[COORD_BITS-1:0];
        if (v < lo) return lo[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    logic [OW-1:0] td;
    logic signed [PW-1:0] a0x, a0y, a1x, a1y, v1x, v1y, fx2, fy2, fx3, fy3;
    logic [2:0] tk;
    logic [8*COORD_BITS+3:0] ow;
    always_comb begin
        td = dl_d_reg[LAT-1];
        {a0x, a0y, a1x, a1y, tk} = td[OW-1:1];
        if (td[0]) begin
            // box: a0 is (x,y), a1 is (x2,y2)
            v1x = a0x; v1y = a1y;
            fx2 = a1x; fy2 = a1y;
            fx3 = a1x; fy3 = a0y;
        end else begin
            v1x = a1x; v1y = a1y;
            fx2 = pex; fy2 = pey; fx3 = psx; fy3 = psy;
        end
        ow = {td[0], tk, sat(fy3), sat(fx3), sat(fy2), sat(fx2),
              sat(v1y), sat(v1x), sat(a0y), sat(a0x)};
    end

    // box quad: v0=(x,y) v1=(x,y2) v2=(x2,y2) v3=(x2,y); corners carried as (x,y),(x2,y2)
    // output FIFO, space reserved by credits
    logic [8*COORD_BITS+3:0] of_mem [FD];
    logic [FD_LOG2-1:0] wp_reg, rp_reg;
    logic [FD_LOG2:0]   cnt_reg;
    logic [8*COORD_BITS+3:0] head;
    assign head = of_mem[rp_reg];
    assign m_valid = cnt_reg != '0;
    assign rd_fifo = m_valid && m_ready;
    assign {m_last, m_kind, m_verts} = head;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (dl_v_reg[LAT-1]) wp_reg <= wp_reg + 1'b1;
            if (rd_fifo) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (FD_LOG2+1)'(dl_v_reg[LAT-1]) - (FD_LOG2+1)'(rd_fifo);
        end
        if (dl_v_reg[LAT-1]) of_mem[wp_reg] <= ow;
    end
endmodule

// ----- src/shadow_quad_generator.sv -----
// Top level of the shadow quad generator: config registers, front, queue, back.
// Depends on sqg_pkg, sqg_front, sqg_queue, sqg_back, sqg_push.
//
//  channel   dir  beat contents
//  s_axis    in   one occluder rectangle
//  m_axis    out  one quad (up to five per rectangle)
//  cfg       in   register index + value
//
// One quad leaves per cycle unless m_axis stalls; a rectangle yields 1 to 5 quads,
// a culled one none. Far vertices are pushed by the pipelined square root and
// divider of the push unit. Reset is synchronous; output stalls back up through
// a 32-entry output FIFO.
module shadow_quad_generator #(
    parameter int COORD_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // rect_x, rect_y, rect_w, rect_h, zero fill
    input  logic [((4*COORD_BITS-2+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y
    output logic [8*COORD_BITS-1:0]      m_tdata,
    // quad_kind
    output logic [2:0]                   m_tuser,
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);
    logic signed [COORD_BITS-1:0] light_x_reg, light_y_reg;
    logic [15:0] radius_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg <= '0; light_y_reg <= '0; radius_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sqg_pkg::REG_LIGHT_X: light_x_reg <= cfg_data[COORD_BITS-1:0];
                sqg_pkg::REG_LIGHT_Y: light_y_reg <= cfg_data[COORD_BITS-1:0];
                sqg_pkg::REG_RADIUS:  radius_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, b_valid, b_ready;
    sqg_pkg::item_t f_item, b_item;

    sqg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .rect_x(s_tdata[COORD_BITS-1:0]),
        .rect_y(s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .rect_w(s_tdata[3*COORD_BITS-2:2*COORD_BITS]),
        .rect_h(s_tdata[4*COORD_BITS-3:3*COORD_BITS-1]),
        .light_x(light_x_reg), .light_y(light_y_reg), .radius(radius_reg),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item));

    sqg_queue u_queue (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

    sqg_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk, .aresetn, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .light_x(light_x_reg), .light_y(light_y_reg), .radius(radius_reg),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_verts(m_tdata),
        .m_kind(m_tuser), .m_last(m_tlast));

    // last flag only on box quads
    a_last_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == sqg_pkg::KIND_BOX)))
        else $error("last flag mismatch");
    // kind code in range
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= sqg_pkg::KIND_BOX))
        else $error("bad quad kind");
endmodule

// ----- bench/tb_shadow_quad_generator.sv -----
// Testbench for shadow_quad_generator: random and directed rectangles under several light settings.
// Depends on sqg_pkg and the shadow_quad_generator RTL; checks every quad against an inline predictor.
module tb_shadow_quad_generator;

    localparam int CB       = 20;
    localparam int SDW      = 80;
    localparam int LIMIT    = 800000;
    localparam int SETTLE   = 40;

    typedef struct {
        logic [8*CB-1:0] verts;
        logic [2:0]      kind;
        logic            last;
    } quad_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // rect_x, rect_y, rect_w, rect_h, zero fill
    logic [SDW-1:0]  s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y
    logic [8*CB-1:0] m_tdata;
    // quad_kind
    logic [2:0]      m_tuser;
    logic            m_tlast;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = sqg_pkg::REG_LIGHT_X;
    logic [31:0]     cfg_data = '0;

    shadow_quad_generator #(.COORD_BITS(CB)) DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow copy of the light registers
    longint light_x, light_y, light_r;

    logic [SDW-1:0] rect_q[$];
    quad_t          quad_q[$];
    int             errors = 0;
    int             rects_sent = 0;
    int             kind_seen[5];
    int             cyc = 0;
    int             in_gap = 0;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic longint sx20(logic [CB-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [CB-1:0] clamp(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[CB-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // point moved 2*radius away from the light along its unit direction
    function automatic void extrude(longint px, longint py, output longint qx, output longint qy);
        longint dx, dy;
        longint unsigned ax, ay, s, len, ox, oy, ext;
        dx = px - light_x;
        dy = py - light_y;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        ext = light_r * 2;
        while (ax >= (64'd1 << 23) || ay >= (64'd1 << 23)) begin
            ax >>= 1;
            ay >>= 1;
        end
        s = ax * ax + ay * ay;
        qx = px;
        qy = py;
        if (s == 0) return;
        len = int_sqrt(s << 14);
        if (len == 0) return;
        ox = ((ax * ext) << 7) / len;
        oy = ((ay * ext) << 7) / len;
        qx += dx < 0 ? -longint'(ox) : longint'(ox);
        qy += dy < 0 ? -longint'(oy) : longint'(oy);
    endfunction

    function automatic quad_t make_quad(longint v[8], logic [2:0] kind, logic last);
        quad_t q;
        for (int i = 0; i < 8; i++) q.verts[i*CB +: CB] = clamp(v[i]);
        q.kind = kind;
        q.last = last;
        return q;
    endfunction

    function automatic void edge_quad(longint ax_, longint ay_, longint bx_, longint by_,
                                      logic [2:0] kind);
        longint v[8];
        v[0] = ax_; v[1] = ay_; v[2] = bx_; v[3] = by_;
        extrude(bx_, by_, v[4], v[5]);
        extrude(ax_, ay_, v[6], v[7]);
        quad_q = {quad_q, make_quad(v, kind, 1'b0)};
    endfunction

    // expected quads for one rectangle beat
    function automatic void predict_quads(logic [SDW-1:0] d);
        longint x, y, w, h, x2, y2, bx, by, bs;
        longint v[8];
        x = sx20(d[19:0]);
        y = sx20(d[39:20]);
        w = d[58:40];
        h = d[77:59];
        x2 = x + w;
        y2 = y + h;
        bx = light_x - light_r;
        by = light_y - light_r;
        bs = 2 * light_r;
        if (light_r == 0) return;
        if (!(bx < x2 && bx + bs > x && by < y2 && by + bs > y)) return;
        if (light_y > y)  edge_quad(x, y, x2, y, sqg_pkg::KIND_TOP);
        if (light_x < x2) edge_quad(x2, y, x2, y2, sqg_pkg::KIND_RIGHT);
        if (light_y < y2) edge_quad(x2, y2, x, y2, sqg_pkg::KIND_BOTTOM);
        if (light_x > x)  edge_quad(x, y2, x, y, sqg_pkg::KIND_LEFT);
        v[0] = x;  v[1] = y;  v[2] = x;  v[3] = y2;
        v[4] = x2; v[5] = y2; v[6] = x2; v[7] = y;
        quad_q = {quad_q, make_quad(v, sqg_pkg::KIND_BOX, 1'b1)};
    endfunction

    function automatic logic [SDW-1:0] rect_beat(longint x, longint y, longint w, longint h);
        logic [SDW-1:0] d;
        logic [63:0] xv, yv, wv, hv;
        xv = x; yv = y; wv = w; hv = h;
        d = '0;
        d[19:0]  = xv[19:0];
        d[39:20] = yv[19:0];
        d[58:40] = wv[18:0];
        d[77:59] = hv[18:0];
        return d;
    endfunction

    // queue one rectangle for the driver
    function automatic void add_rect(longint x, longint y, longint w, longint h);
        rect_q = {rect_q, rect_beat(x, y, w, h)};
    endfunction

    // rectangle driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (rect_q.size() > 0) begin
                s_tdata  <= rect_q.pop_front();
                s_tvalid <= 1'b1;
                in_gap   <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    int out_hold = 0;
    always @(posedge aclk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            out_hold <= pick_gap();
        end
    end

    // monitor: accepted rectangles feed the predictor, quads are checked in order
    always @(posedge aclk) begin
        quad_t e;
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("%0t timeout with %0d quads outstanding", $time, quad_q.size());
            $display("status: fail");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            rects_sent <= rects_sent + 1;
            predict_quads(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (quad_q.size() == 0) begin
                $display("%0t unexpected quad kind=%0d data=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                e = quad_q.pop_front();
                if (m_tuser < 5) kind_seen[m_tuser]++;
                for (int i = 0; i < 8; i++)
                    if (m_tdata[i*CB +: CB] !== e.verts[i*CB +: CB]) begin
                        $display("%0t vertex coord %0d: expected %h actual %h", $time, i,
                                 e.verts[i*CB +: CB], m_tdata[i*CB +: CB]);
                        errors++;
                    end
                if (m_tuser !== e.kind) begin
                    $display("%0t quad_kind: expected %0d actual %0d", $time, e.kind, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t last_quad: expected %0b actual %0b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, longint val);
        logic [63:0] v;
        v = val;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[31:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sqg_pkg::REG_LIGHT_X: light_x = sx20(v[19:0]);
            sqg_pkg::REG_LIGHT_Y: light_y = sx20(v[19:0]);
            default:              light_r = v[15:0];
        endcase
    endtask

    task automatic drain();
        while (!(rect_q.size() == 0 && !s_tvalid && quad_q.size() == 0)) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_light(longint lx, longint ly, longint r);
        write_reg(sqg_pkg::REG_LIGHT_X, lx);
        write_reg(sqg_pkg::REG_LIGHT_Y, ly);
        write_reg(sqg_pkg::REG_RADIUS, r);
    endtask

    // mostly rectangles around the light, some raw noise
    task automatic random_rects(int n);
        longint span, x, y, w, h;
        for (int i = 0; i < n; i++) begin
            span = light_r < 64 ? 64 : light_r;
            if ($urandom_range(0, 9) == 0) begin
                add_rect($urandom, $urandom, $urandom, $urandom);
            end else begin
                x = light_x + longint'($urandom_range(0, 32'(4 * span))) - 3 * span;
                y = light_y + longint'($urandom_range(0, 32'(4 * span))) - 3 * span;
                w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 524287)
                                              : $urandom_range(0, 32'(3 * span));
                h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 524287)
                                              : $urandom_range(0, 32'(3 * span));
                add_rect(x, y, w, h);
            end
        end
    endtask

    initial begin
        light_x = 0; light_y = 0; light_r = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // at reset the radius is zero: nothing comes out
        add_rect(-50, -50, 100, 100);
        drain();

        // directed: light at origin
        set_light(0, 0, 160);
        add_rect(-50, -50, 100, 100);     // light inside, all four faces
        add_rect(-150, -10, 50, 20);      // left of light
        add_rect(60, -10, 50, 20);        // right of light
        add_rect(-10, -150, 20, 50);      // above
        add_rect(-10, 60, 20, 50);        // below
        add_rect(-320, -10, 160, 20);     // touches box edge, culled
        add_rect(160, -10, 20, 20);       // starts at box end, culled
        add_rect(-159, -10, 0, 0);        // degenerate
        add_rect(0, 0, 0, 0);             // point on the light
        add_rect(5000, 5000, 10, 10);     // far away
        drain();

        // extreme radius and coordinates, pushes saturate
        set_light(524287, 524287, 65535);
        add_rect(524287, 524287, 524287, 524287);
        add_rect(-524288, -524288, 524287, 524287);
        add_rect(500000, 500000, 0, 0);
        add_rect(470000, 470000, 524287, 100);
        random_rects(75);
        drain();

        set_light(-524288, -524288, 1);
        add_rect(-524288, -524288, 524287, 524287);
        add_rect(-524289, -524289, 1, 1);
        add_rect(-524288, -524288, 1, 1);
        random_rects(75);
        drain();

        set_light(0, 0, 0);
        random_rects(20);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_light(longint'($urandom_range(0, 1048575)) - 524288,
                      longint'($urandom_range(0, 1048575)) - 524288,
                      p == 0 ? 65535 : $urandom_range(1, 4000));
            random_rects(70);
            drain();
        end

        $display("%0d rectangles over 9 light settings; quads top %0d right %0d bottom %0d",
                 rects_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("left %0d box %0d, %0d mismatches", kind_seen[3], kind_seen[4], errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
